// File: src/ssi_pkg.sv
package ssi_pkg;

    // Position width actually used; higher index bits are ignored
    localparam int INDEX_BITS = 16;
    localparam int WORD_BITS  = 32;
    localparam int REM_W      = 5;
    localparam int WORDS_W    = (INDEX_BITS > REM_W) ? INDEX_BITS - REM_W : 1;
    localparam int CNT_W      = INDEX_BITS;
    localparam int POP_W      = 6;

    // Linear congruential step constants
    localparam logic [31:0] LCG_MUL = 32'd1103515245;
    localparam logic [31:0] LCG_ADD = 32'd12345;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic init;
        logic step;
        logic fin;
        logic write;
    } ssi_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic words_zero;
    } ssi_stat_t;

    // Popcount of a 32-bit word as an adder tree
    function automatic logic [POP_W-1:0] ones32(input logic [31:0] x);
        logic [31:0] v;
        begin
            v = (x & 32'h5555_5555) + ((x >> 1) & 32'h5555_5555);
            v = (v & 32'h3333_3333) + ((v >> 2) & 32'h3333_3333);
            v = (v & 32'h0f0f_0f0f) + ((v >> 4) & 32'h0f0f_0f0f);
            v = (v & 32'h00ff_00ff) + ((v >> 8) & 32'h00ff_00ff);
            v = (v & 32'h0000_ffff) + ((v >> 16) & 32'h0000_ffff);
            return v[POP_W-1:0];
        end
    endfunction

endpackage

// File: src/ssi_dpath.sv
module ssi_dpath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ssi_pkg::ssi_cmd_t      cmd,
    output ssi_pkg::ssi_stat_t     stat,
    input  logic [31:0]            seed_in,
    input  logic [15:0]            index_in,
    output logic [31:0]            result
);

    logic [31:0]                      seed_reg;
    logic [ssi_pkg::INDEX_BITS-1:0]   index_reg;
    logic [31:0]                      w_reg;
    logic [ssi_pkg::CNT_W-1:0]        count_reg;
    logic [ssi_pkg::WORDS_W-1:0]      words_reg;
    logic                             bit_reg;
    logic [31:0]                      result_reg;

    logic [31:0]                      mul_in;
    logic [31:0]                      w_next;
    logic [ssi_pkg::REM_W-1:0]        rem;
    logic [31:0]                      low_mask;
    logic [ssi_pkg::POP_W-1:0]        pop_full;
    logic [ssi_pkg::POP_W-1:0]        pop_low;
    logic [31:0]                      count_ext;
    logic [31:0]                      index_ext;

    // Share one multiplier between the first word and each advance
    assign mul_in   = cmd.init ? seed_reg : w_reg;
    assign w_next   = mul_in * ssi_pkg::LCG_MUL + ssi_pkg::LCG_ADD;

    // Popcounts of the whole word and of its low partial bits
    assign rem      = index_reg[ssi_pkg::REM_W-1:0];
    assign low_mask = (32'd1 << rem) - 32'd1;
    assign pop_full = ssi_pkg::ones32(w_reg);
    assign pop_low  = ssi_pkg::ones32(w_reg & low_mask);

    assign count_ext = 32'(count_reg);
    assign index_ext = 32'(index_reg);

    assign stat.words_zero = (words_reg == '0);
    assign result          = result_reg;

    // Hold operands, iterate the word and running count, form the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg   <= '0;
            index_reg  <= '0;
            w_reg      <= '0;
            count_reg  <= '0;
            words_reg  <= '0;
            bit_reg    <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                seed_reg  <= seed_in;
                index_reg <= ssi_pkg::INDEX_BITS'(index_in);
            end
            if (cmd.init)
            begin
                w_reg     <= w_next;
                count_reg <= '0;
                words_reg <= ssi_pkg::WORDS_W'(index_reg >> ssi_pkg::REM_W);
            end
            if (cmd.step)
            begin
                w_reg     <= w_next;
                count_reg <= count_reg + ssi_pkg::CNT_W'(pop_full);
                words_reg <= words_reg - 1'b1;
            end
            if (cmd.fin)
            begin
                count_reg <= count_reg + ssi_pkg::CNT_W'(pop_low);
                bit_reg   <= w_reg[rem];
            end
            if (cmd.write)
            begin
                if (bit_reg)
                    result_reg <= seed_reg + ~count_ext;
                else
                    result_reg <= seed_reg - count_ext + index_ext;
            end
        end
    end

endmodule

// File: src/ssi_ctrl.sv
module ssi_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    output ssi_pkg::ssi_cmd_t      cmd,
    input  ssi_pkg::ssi_stat_t     stat
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_INIT,
        S_RUN,
        S_WRITE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Decode commands and next state
    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                cmd.init   = 1'b1;
                state_next = S_RUN;
            end
            S_RUN:
            begin
                if (stat.words_zero)
                begin
                    cmd.fin    = 1'b1;
                    state_next = S_WRITE;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            S_WRITE:
            begin
                if (slot_free)
                begin
                    cmd.write      = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and the result-valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten before transaction");

    a_step_has_words: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> !stat.words_zero)
        else $error("word advance with no words left");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (!in_ready && cmd.init))
        else $error("accepted transaction not followed by init");

    a_write_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write |=> out_valid)
        else $error("result written but not presented");
`endif

endmodule

// File: src/seeded_index_scramble.sv
// Scrambled index from a seed and a position. Each input transaction
// (seed, index) yields exactly one result and nothing is kept between
// transactions. One item is worked at a time: the next input is taken
// the cycle after the result is written. The run time is set by the
// single 32x32 linear congruential multiplier, which advances one word
// per clock. A finished result waits in an output register; only bits
// below ssi_pkg::INDEX_BITS of index are used.
module seeded_index_scramble (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [31:0] seed, [47:32] index
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] scrambled
);

    ssi_pkg::ssi_cmd_t  cmd;
    ssi_pkg::ssi_stat_t stat;

    ssi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    ssi_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .seed_in  (s_tdata[31:0]),
        .index_in (s_tdata[47:32]),
        .result   (m_tdata)
    );

endmodule
